// File: sv/subset_sum_transform_unit_assert.svh
`ifndef SUBSET_SUM_TRANSFORM_UNIT_ASSERT_SVH
`define SUBSET_SUM_TRANSFORM_UNIT_ASSERT_SVH

// check a condition in the same cycle
`define SSUM_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// check a condition in the following cycle
`define SSUM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/ssum_pkg.sv
package ssum_pkg;

   localparam int MAX_BITS_DEFAULT = 10;
   localparam int DATA_W           = 32;
   localparam int INDEX_W          = 10;
   localparam int CFG_W            = 4;

   localparam logic [CFG_W-1:0] BITS_RESET = 4'd3;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef logic [DATA_W-1:0] word_type;

endpackage

// File: sv/subset_sum_transform_unit.sv
// Sum-over-subsets transform unit. While busy is low, load requests store one value per cycle
// at the next mask position; the load that fills all 2^n entries (n from csr_bits_in_use,
// clamped to 1..MAX_BITS) starts the in-place transform, during which busy stays high: one mask
// visited per cycle, each reading two entries through the table's two read ports; masks with the
// current bit set write the sum back in the next cycle. A read request holds busy for one cycle
// and its result appears on the rsp_ ports, marked by rsp_strobe, in the cycle after the request
// is taken; the receiver cannot stall it and must take it then. A read before the transform
// finishes returns 0 with rsp_not_ready set. Configuration writes are taken only while busy and
// start are both low and abort any data set in progress. Table contents are undefined after
// reset; no clearing pass is run.
module subset_sum_transform_unit import ssum_pkg::*; #(
   parameter int MAX_BITS = MAX_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic                     req_opcode,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic [INDEX_W-1:0]       req_index,
   output logic                     rsp_strobe,
   output logic signed [DATA_W-1:0] rsp_subset_sum,
   output logic                     rsp_not_ready,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CFG_W-1:0]         csr_bits_in_use
);

`include "subset_sum_transform_unit_assert.svh"

   localparam int AW    = MAX_BITS;
   localparam int CNT_W = AW + 1;
   localparam int NBW   = $clog2(MAX_BITS + 1);
   localparam int CW    = (NBW > CFG_W) ? NBW : CFG_W;
   localparam int BW    = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RESP  = 2'd1;
   localparam logic [1:0] ST_XFORM = 2'd2;
   localparam logic [1:0] ST_DRAIN = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CFG_W-1:0] bits_ff, bits_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             done_ff, done_in;
   logic [AW-1:0]    m_ff, m_in;
   logic [BW-1:0]    b_ff, b_in;
   logic             wr_pend_ff, wr_pend_in;
   logic [AW-1:0]    wr_addr_ff, wr_addr_in;
   logic             rd_done_ff, rd_done_in;

   logic [CW-1:0]    n_w;
   logic [CW-1:0]    n_last_w;
   logic [AW-1:0]    addr_mask_w;
   logic [CNT_W-1:0] size_w;
   logic [AW-1:0]    bit_sel_w;
   logic             accept_w;
   logic             load_w;
   logic             read_w;
   logic             restart_w;
   logic [AW-1:0]    load_pos_w;
   logic [CNT_W-1:0] load_cnt_w;
   logic             last_issue_w;

   logic             mem_wr_en;
   logic [AW-1:0]    mem_wr_addr;
   word_type         mem_wr_data;
   logic [AW-1:0]    rd_addr_a;
   logic [AW-1:0]    rd_addr_b;
   word_type         rd_data_a;
   word_type         rd_data_b;

   always_comb begin
      priority if (bits_ff == '0) begin
         n_w = CW'(1);
      end else if (CW'(bits_ff) > CW'(MAX_BITS)) begin
         n_w = CW'(MAX_BITS);
      end else begin
         n_w = CW'(bits_ff);
      end
   end

   assign n_last_w    = n_w - CW'(1);
   assign addr_mask_w = ~({AW{1'b1}} << n_w);
   assign size_w      = CNT_W'(1) << n_w;
   assign bit_sel_w   = AW'(1) << b_ff;

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE) && !start;
   assign accept_w  = start && !busy;
   assign load_w    = accept_w && (req_opcode == OP_LOAD);
   assign read_w    = accept_w && (req_opcode == OP_READ);

   assign restart_w    = done_ff || (count_ff >= size_w);
   assign load_pos_w   = restart_w ? '0 : (count_ff[AW-1:0] & addr_mask_w);
   assign load_cnt_w   = restart_w ? CNT_W'(1) : count_ff + CNT_W'(1);
   assign last_issue_w = (m_ff == addr_mask_w) && (CW'(b_ff) == n_last_w);

   assign mem_wr_en   = load_w || wr_pend_ff;
   assign mem_wr_addr = load_w ? load_pos_w : wr_addr_ff;
   assign mem_wr_data = load_w ? word_type'(req_value) : rd_data_a + rd_data_b;
   assign rd_addr_a   = (state_ff == ST_XFORM) ? m_ff : (AW'(req_index) & addr_mask_w);
   assign rd_addr_b   = m_ff ^ bit_sel_w;

   ssum_table #(
      .AW (AW)
   ) u_table (
      .clock     (clock),
      .wr_en     (mem_wr_en),
      .wr_addr   (mem_wr_addr),
      .wr_data   (mem_wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   always_comb begin
      state_in   = state_ff;
      bits_in    = bits_ff;
      count_in   = count_ff;
      done_in    = done_ff;
      m_in       = m_ff;
      b_in       = b_ff;
      wr_pend_in = 1'b0;
      wr_addr_in = m_ff;
      rd_done_in = rd_done_ff;
      unique case (state_ff)
         ST_IDLE: begin
            priority if (csr_valid && csr_ready) begin
               bits_in  = csr_bits_in_use;
               count_in = '0;
               done_in  = 1'b0;
            end else if (load_w) begin
               count_in = load_cnt_w;
               done_in  = 1'b0;
               if (load_cnt_w >= size_w) begin
                  state_in = ST_XFORM;
                  m_in     = '0;
                  b_in     = '0;
               end
            end else if (read_w) begin
               state_in   = ST_RESP;
               rd_done_in = done_ff;
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         ST_XFORM: begin
            // update only masks with the current bit set
            wr_pend_in = (m_ff & bit_sel_w) != '0;
            if (m_ff == addr_mask_w) begin
               m_in = '0;
               if (last_issue_w) begin
                  state_in = ST_DRAIN;
               end else begin
                  b_in = b_ff + BW'(1);
               end
            end else begin
               m_in = m_ff + AW'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_IDLE;
            done_in  = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         bits_ff    <= BITS_RESET;
         count_ff   <= '0;
         done_ff    <= 1'b0;
         m_ff       <= '0;
         b_ff       <= '0;
         wr_pend_ff <= 1'b0;
         rd_done_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         bits_ff    <= bits_in;
         count_ff   <= count_in;
         done_ff    <= done_in;
         m_ff       <= m_in;
         b_ff       <= b_in;
         wr_pend_ff <= wr_pend_in;
         rd_done_ff <= rd_done_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff <= wr_addr_in;
   end

   assign rsp_strobe     = (state_ff == ST_RESP);
   assign rsp_subset_sum = rd_done_ff ? rd_data_a : '0;
   assign rsp_not_ready  = !rd_done_ff;

   `SSUM_ASSERT_NOW(no_rw_collision, wr_pend_ff && (state_ff == ST_XFORM), (rd_addr_a != wr_addr_ff) && (rd_addr_b != wr_addr_ff), "transform read hits entry being written")
   `SSUM_ASSERT_NEXT(read_gets_response, read_w, rsp_strobe && (rsp_not_ready != $past(done_ff)), "read request without matching response")
   `SSUM_ASSERT_NEXT(last_load_starts_transform, load_w && !csr_valid && (load_cnt_w >= size_w), (state_ff == ST_XFORM) && !done_ff, "final load did not start transform")
   `SSUM_ASSERT_NOW(strobe_only_after_read, rsp_strobe, $past(read_w), "response without read request")

endmodule

// File: sv/ssum_table.sv
module ssum_table import ssum_pkg::*; #(
   parameter int AW = MAX_BITS_DEFAULT
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  word_type      wr_data,
   input  logic [AW-1:0] rd_addr_a,
   input  logic [AW-1:0] rd_addr_b,
   output word_type      rd_data_a,
   output word_type      rd_data_b
);

   localparam int DEPTH = 1 << AW;

   word_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

// File: sim/tb_subset_sum_transform_unit.sv
module tb_subset_sum_transform_unit;
   import ssum_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned WATCHDOG_LIMIT = 40000;

   typedef struct packed {
      word_type sum;
      logic     not_ready;
   } sum_answer_type;

   class zeta_scoreboard;
      word_type         sums [1 << MAX_BITS_DEFAULT];
      int unsigned      fill_count;
      bit               sums_ready;
      logic [CFG_W-1:0] bits_reg;
      sum_answer_type   answers_q [$];
      int unsigned      errors;

      function new();
         bits_reg   = BITS_RESET;
         fill_count = 0;
         sums_ready = 1'b0;
         errors     = 0;
      endfunction

      function int unsigned mask_bits();
         int unsigned n;
         n = bits_reg;
         if (n < 1) n = 1;
         if (n > MAX_BITS_DEFAULT) n = MAX_BITS_DEFAULT;
         return n;
      endfunction

      function int unsigned pending();
         return answers_q.size();
      endfunction

      function void write_bits(logic [CFG_W-1:0] bits);
         bits_reg   = bits;
         fill_count = 0;
         sums_ready = 1'b0;
      endfunction

      function void note_request(logic opcode, word_type value, logic [INDEX_W-1:0] index);
         int unsigned n;
         int unsigned size;
         int unsigned b;
         int unsigned m;
         sum_answer_type ans;
         n    = mask_bits();
         size = 1 << n;
         if (opcode == OP_LOAD) begin
            if (sums_ready || fill_count >= size) begin
               fill_count = 0;
               sums_ready = 1'b0;
            end
            sums[fill_count & (size - 1)] = value;
            fill_count++;
            if (fill_count >= size) begin
               for (b = 0; b < n; b++) begin
                  for (m = 0; m < size; m++) begin
                     if ((m >> b) & 1) sums[m] = sums[m] + sums[m ^ (1 << b)];
                  end
               end
               sums_ready = 1'b1;
            end
         end else begin
            if (!sums_ready) begin
               ans.sum       = '0;
               ans.not_ready = 1'b1;
            end else begin
               ans.sum       = sums[index & (size - 1)];
               ans.not_ready = 1'b0;
            end
            answers_q.push_back(ans);
         end
      endfunction

      function void check_response(word_type sum, logic not_ready);
         sum_answer_type want;
         if (answers_q.size() == 0) begin
            $error("unexpected response: subset_sum %0d not_ready %0b", $signed(sum), not_ready);
            errors++;
            return;
         end
         want = answers_q.pop_front();
         if (sum !== want.sum) begin
            $error("subset_sum: expected %0d, got %0d", $signed(want.sum), $signed(sum));
            errors++;
         end
         if (not_ready !== want.not_ready) begin
            $error("not_ready: expected %0b, got %0b", want.not_ready, not_ready);
            errors++;
         end
      endfunction
   endclass

   logic                     clock           = 1'b0;
   logic                     reset           = 1'b1;
   logic                     start           = 1'b0;
   logic                     busy;
   logic                     req_opcode      = OP_LOAD;
   logic signed [DATA_W-1:0] req_value       = '0;
   logic [INDEX_W-1:0]       req_index       = '0;
   logic                     rsp_strobe;
   logic signed [DATA_W-1:0] rsp_subset_sum;
   logic                     rsp_not_ready;
   logic                     csr_valid       = 1'b0;
   logic                     csr_ready;
   logic [CFG_W-1:0]         csr_bits_in_use = BITS_RESET;

   zeta_scoreboard zeta = new();
   int unsigned    gap_pct     = 0;
   int unsigned    issued      = 0;
   int unsigned    idle_cycles = 0;

   subset_sum_transform_unit #(
      .MAX_BITS(MAX_BITS_DEFAULT)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_value      (req_value),
      .req_index      (req_index),
      .rsp_strobe     (rsp_strobe),
      .rsp_subset_sum (rsp_subset_sum),
      .rsp_not_ready  (rsp_not_ready),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_bits_in_use(csr_bits_in_use)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) zeta.note_request(req_opcode, req_value, req_index);
         if (rsp_strobe) zeta.check_response(rsp_subset_sum, rsp_not_ready);
         if (csr_valid && csr_ready) zeta.write_bits(csr_bits_in_use);
         if ((start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
               $display("tb_subset_sum_transform_unit: FAIL");
               $finish;
            end
         end
      end
   end

   task automatic issue(input logic opcode, input word_type value,
                        input logic [INDEX_W-1:0] index);
      while ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start      <= 1'b1;
      req_opcode <= opcode;
      req_value  <= value;
      req_index  <= index;
      do @(posedge clock); while (busy);
      issued++;
   endtask

   task automatic load(input word_type value);
      issue(OP_LOAD, value, INDEX_W'($urandom_range(1023)));
   endtask

   task automatic read(input logic [INDEX_W-1:0] index);
      issue(OP_READ, word_type'($urandom), index);
   endtask

   // hold off until every read request has been answered
   task automatic hold_until_drained();
      start <= 1'b0;
      do @(negedge clock); while (zeta.pending() != 0);
      @(posedge clock);
   endtask

   task automatic write_bits(input logic [CFG_W-1:0] bits);
      hold_until_drained();
      repeat (2) @(posedge clock);
      while (busy) @(posedge clock);
      csr_valid       <= 1'b1;
      csr_bits_in_use <= bits;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic word_type pick_value();
      case ($urandom_range(7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return '1;
         3: return '0;
         default: return word_type'($urandom);
      endcase
   endfunction

   function automatic logic [INDEX_W-1:0] pick_index();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return INDEX_W'($urandom_range(1023));
      endcase
   endfunction

   function automatic logic [CFG_W-1:0] pick_bits();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 12) return '0;
      if (r < 65) return CFG_W'($urandom_range(1, 3));
      if (r < 88) return CFG_W'($urandom_range(4, 5));
      if (r < 95) return CFG_W'(6);
      return CFG_W'($urandom_range(7, 15));
   endfunction

   task automatic random_round();
      int unsigned size;
      int unsigned loads;
      int unsigned k;
      if ($urandom_range(99) < 35) write_bits(pick_bits());
      else if ($urandom_range(99) < 10) hold_until_drained();
      size = 1 << zeta.mask_bits();
      // cut the data set short when it is large or at random
      if (size > 64 || $urandom_range(99) < 12)
         loads = $urandom_range(1, (size > 16) ? 16 : size);
      else
         loads = size;
      if ($urandom_range(99) < 25) read(pick_index());
      for (k = 0; k < loads; k++) begin
         load(pick_value());
         if ($urandom_range(99) < 4) read(pick_index());
      end
      repeat ($urandom_range(1, 8)) read(pick_index());
   endtask

   initial begin
      int unsigned p;
      int unsigned k;
      int unsigned target;
      int unsigned phase_gap [4];
      phase_gap = '{0, 46, 0, 34};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      read(10'd5);
      load(32'h7fff_ffff);
      load(32'h7fff_ffff);
      load(32'h8000_0000);
      load(32'hffff_ffff);
      load(32'h0000_0000);
      load(32'h0000_0001);
      load(32'h8000_0000);
      load(32'h1234_5678);
      read(10'd0);
      read(10'd7);
      read(10'd1023);
      hold_until_drained();
      read(10'd8);
      read(10'd6);
      load(32'hdead_beef);
      read(10'd0);
      write_bits(4'd0);
      load(32'hffff_ffff);
      load(32'h0000_0001);
      read(10'd1);
      read(10'd1022);

      write_bits(4'd15);
      repeat (3) load(pick_value());
      read(pick_index());
      write_bits(4'd8);
      for (k = 0; k < (1 << 8); k++) load(pick_value());
      repeat (12) read(pick_index());
      write_bits(4'd10);
      repeat (3) load(pick_value());
      read(pick_index());

      for (p = 0; p < 4; p++) begin
         gap_pct = phase_gap[p];
         target  = issued + 160;
         hold_until_drained();
         while (issued < target) random_round();
      end

      start <= 1'b0;
      repeat (2) @(posedge clock);
      do @(negedge clock); while (zeta.pending() != 0 || busy);
      repeat (20) @(posedge clock);
      if (zeta.errors == 0)
         $display("tb_subset_sum_transform_unit: PASS");
      else
         $display("tb_subset_sum_transform_unit: FAIL");
      $finish;
   end

endmodule

// File: files.f
+incdir+sv
sv/ssum_pkg.sv
sv/ssum_table.sv
sv/subset_sum_transform_unit.sv
sim/tb_subset_sum_transform_unit.sv
